FILE: design/hrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hrd_pkg;

	// Width of the content length value and of the body byte counter
	localparam int LEN_BITS = 32;
	// Width of the reported length field
	localparam int BL_W = 32;

	localparam int NAME_LEN   = 15;
	localparam int NAME_IDX_W = $clog2(NAME_LEN + 1);

	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	localparam logic [7:0] EXACT_NAME [NAME_LEN] = '{
		"C", "o", "n", "t", "e", "n", "t", "-", "L", "e", "n", "g", "t", "h", ":"
	};
	localparam logic [7:0] LOWER_NAME [NAME_LEN] = '{
		"c", "o", "n", "t", "e", "n", "t", "-", "l", "e", "n", "g", "t", "h", ":"
	};

	// One classified byte as it travels from the front to the back
	typedef struct packed {
		logic [7:0]          byte_val;
		logic                is_digit;
		logic [3:0]          digit;
		logic                is_blank;
		logic                is_cr;
		logic                is_lf;
		logic [NAME_LEN-1:0] exact_hit;
		logic [NAME_LEN-1:0] lower_hit;
	} hrd_class_t;

endpackage

`default_nettype wire

FILE: design/hrd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module hrd_front (
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [7:0]        data_byte,
	output logic                   q_valid,
	input  wire logic              q_stall,
	output hrd_pkg::hrd_class_t    q_data
);
	import hrd_pkg::*;

	always_comb begin
		q_data.byte_val = data_byte;
		q_data.is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
		q_data.digit    = 4'(data_byte - CH_ZERO);
		q_data.is_blank = (data_byte == CH_SP) || (data_byte == CH_TAB);
		q_data.is_cr    = (data_byte == CH_CR);
		q_data.is_lf    = (data_byte == CH_LF);
		// compare against every name position so the back only selects one bit
		for (int i = 0; i < NAME_LEN; i++) begin
			q_data.exact_hit[i] = (data_byte == EXACT_NAME[i]);
			q_data.lower_hit[i] = (data_byte == LOWER_NAME[i]);
		end
	end

	assign q_valid  = in_valid;
	assign in_stall = q_stall;

endmodule

`default_nettype wire

FILE: design/hrd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module hrd_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push_valid,
	output logic                      push_stall,
	input  wire hrd_pkg::hrd_class_t  push_data,
	output logic                      pop_valid,
	input  wire logic                 pop,
	output hrd_pkg::hrd_class_t       pop_data
);
	import hrd_pkg::*;

	hrd_class_t  mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	logic        take;

	assign push_stall = (count_q == 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && !push_stall;
	assign take       = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (take)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !take)
				count_q <= count_q + 2'd1;
			else if (take && !push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

FILE: design/hrd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module hrd_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 q_valid,
	output logic                      q_pop,
	input  wire hrd_pkg::hrd_class_t  q_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [7:0]                byte_out,
	output logic                      in_body,
	output logic                      headers_done,
	output logic                      request_end,
	output logic [hrd_pkg::BL_W-1:0]  body_length
);
	import hrd_pkg::*;

	typedef enum logic [1:0] {
		VS_NONE,
		VS_SKIP,
		VS_DIGITS,
		VS_FINAL
	} vstage_t;

	typedef struct packed {
		vstage_t             stage;
		logic [LEN_BITS-1:0] value;
	} parse_t;

	typedef struct packed {
		logic [NAME_IDX_W-1:0] progress;
		logic                  done;
	} match_t;

	function automatic parse_t parse_step(vstage_t st, logic [LEN_BITS-1:0] v,
			hrd_class_t c);
		parse_t             r;
		logic [LEN_BITS+3:0] acc;
		logic               ovf;
		r.stage = st;
		r.value = v;
		acc = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {{LEN_BITS{1'b0}}, c.digit};
		ovf = |acc[LEN_BITS+3:LEN_BITS];
		unique case (st)
			VS_SKIP: begin
				if (!c.is_blank) begin
					if (!c.is_digit || ovf) begin
						r.value = '0;
						r.stage = VS_FINAL;
					end else begin
						r.value = acc[LEN_BITS-1:0];
						r.stage = VS_DIGITS;
					end
				end
			end
			VS_DIGITS: begin
				if (!c.is_digit) begin
					r.stage = VS_FINAL;
				end else if (ovf) begin
					r.value = '0;
					r.stage = VS_FINAL;
				end else begin
					r.value = acc[LEN_BITS-1:0];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic match_t match_step(logic [NAME_IDX_W-1:0] p,
			logic [NAME_LEN-1:0] hit);
		match_t r;
		logic [NAME_IDX_W-1:0] np;
		if (hit[p])
			np = p + NAME_IDX_W'(1);
		else if (hit[0])
			np = NAME_IDX_W'(1);
		else
			np = '0;
		r.done = 1'b0;
		if (np == NAME_IDX_W'(NAME_LEN)) begin
			r.done = 1'b1;
			np = '0;
		end
		r.progress = np;
		return r;
	endfunction

	logic                  body_phase_q, body_phase_d;
	logic [1:0]            term_q, term_d;
	logic [NAME_IDX_W-1:0] ex_prog_q, ex_prog_d;
	logic [NAME_IDX_W-1:0] lo_prog_q, lo_prog_d;
	vstage_t               ex_stage_q, ex_stage_d;
	vstage_t               lo_stage_q, lo_stage_d;
	logic [LEN_BITS-1:0]   ex_val_q, ex_val_d;
	logic [LEN_BITS-1:0]   lo_val_q, lo_val_d;
	logic [LEN_BITS-1:0]   remain_q, remain_d;

	logic                  out_valid_q;
	logic [7:0]            byte_q;
	logic                  in_body_q;
	logic                  done_q;
	logic                  end_q;
	logic [BL_W-1:0]       len_q;

	logic                  body_c, done_c, end_c;
	logic [LEN_BITS-1:0]   len_c;
	parse_t                ex_parse, lo_parse;
	match_t                ex_match, lo_match;

	assign q_pop = q_valid && (!out_valid_q || !out_stall);

	always_comb begin
		body_phase_d = body_phase_q;
		term_d       = term_q;
		ex_prog_d    = ex_prog_q;
		lo_prog_d    = lo_prog_q;
		ex_stage_d   = ex_stage_q;
		lo_stage_d   = lo_stage_q;
		ex_val_d     = ex_val_q;
		lo_val_d     = lo_val_q;
		remain_d     = remain_q;
		body_c       = 1'b0;
		done_c       = 1'b0;
		end_c        = 1'b0;
		len_c        = '0;

		ex_parse = parse_step(ex_stage_q, ex_val_q, q_data);
		lo_parse = parse_step(lo_stage_q, lo_val_q, q_data);
		ex_match = match_step(ex_prog_q, q_data.exact_hit);
		lo_match = match_step(lo_prog_q, q_data.lower_hit);

		if (body_phase_q) begin
			body_c   = 1'b1;
			remain_d = remain_q - LEN_BITS'(1);
			if (remain_q == LEN_BITS'(1)) begin
				end_c        = 1'b1;
				body_phase_d = 1'b0;
			end
		end else begin
			// a name matcher runs only until its first match; the parser takes over
			if (ex_stage_q == VS_NONE) begin
				ex_prog_d  = ex_match.progress;
				ex_stage_d = ex_match.done ? VS_SKIP : VS_NONE;
			end else begin
				ex_stage_d = ex_parse.stage;
				ex_val_d   = ex_parse.value;
			end
			if (lo_stage_q == VS_NONE) begin
				lo_prog_d  = lo_match.progress;
				lo_stage_d = lo_match.done ? VS_SKIP : VS_NONE;
			end else begin
				lo_stage_d = lo_parse.stage;
				lo_val_d   = lo_parse.value;
			end

			if (term_q == 2'd3 && q_data.is_lf) begin
				done_c = 1'b1;
				if (ex_stage_d != VS_NONE)
					len_c = ex_val_d;
				else if (lo_stage_d != VS_NONE)
					len_c = lo_val_d;
				term_d     = 2'd0;
				ex_prog_d  = '0;
				lo_prog_d  = '0;
				ex_stage_d = VS_NONE;
				lo_stage_d = VS_NONE;
				ex_val_d   = '0;
				lo_val_d   = '0;
				if (len_c == '0) begin
					end_c = 1'b1;
				end else begin
					body_phase_d = 1'b1;
					remain_d     = len_c;
				end
			end else if ((term_q == 2'd0 || term_q == 2'd2) && q_data.is_cr) begin
				term_d = term_q + 2'd1;
			end else if (term_q == 2'd1 && q_data.is_lf) begin
				term_d = 2'd2;
			end else begin
				term_d = q_data.is_cr ? 2'd1 : 2'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_phase_q <= 1'b0;
			term_q       <= 2'd0;
			ex_prog_q    <= '0;
			lo_prog_q    <= '0;
			ex_stage_q   <= VS_NONE;
			lo_stage_q   <= VS_NONE;
			ex_val_q     <= '0;
			lo_val_q     <= '0;
			remain_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (q_pop) begin
				body_phase_q <= body_phase_d;
				term_q       <= term_d;
				ex_prog_q    <= ex_prog_d;
				lo_prog_q    <= lo_prog_d;
				ex_stage_q   <= ex_stage_d;
				lo_stage_q   <= lo_stage_d;
				ex_val_q     <= ex_val_d;
				lo_val_q     <= lo_val_d;
				remain_q     <= remain_d;
			end
			// hold a stalled result until transfer
			out_valid_q <= q_pop || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			byte_q    <= q_data.byte_val;
			in_body_q <= body_c;
			done_q    <= done_c;
			end_q     <= end_c;
			len_q     <= BL_W'(len_c);
		end
	end

	assign out_valid    = out_valid_q;
	assign byte_out     = byte_q;
	assign in_body      = in_body_q;
	assign headers_done = done_q;
	assign request_end  = end_q;
	assign body_length  = len_q;

	a_body_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		body_phase_q |-> (remain_q != '0))
		else $error("body phase with zero bytes remaining");

	a_match_parked: assert property (@(posedge clk) disable iff (!arst_n)
		(ex_stage_q != VS_NONE) || (lo_stage_q != VS_NONE) |->
			((ex_stage_q == VS_NONE) || (ex_prog_q == '0)) &&
			((lo_stage_q == VS_NONE) || (lo_prog_q == '0)))
		else $error("name matcher advanced after its match");

	a_len_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !done_q |-> (len_q == '0))
		else $error("length reported outside header terminator");

	a_done_not_body: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_q |-> !in_body_q)
		else $error("header terminator marked as body byte");

endmodule

`default_nettype wire

FILE: design/http_request_delimiter_top.sv
// Frames HTTP/1.x requests on one connection's byte stream. Every accepted
// byte yields exactly one result: the byte itself, an in_body flag, a
// headers_done flag on the final LF of CR LF CR LF (with body_length, the
// first "Content-Length:" value, else the first "content-length:" value,
// else 0), and request_end on the last byte of each request. The block
// takes one byte per cycle while the output is not stalled; the front
// classifies each byte, a two-entry queue decouples it from the back,
// whose single per-byte state update (name matchers, decimal parser, body
// counter) sets that rate. Each byte is stored in the queue, and its result
// is registered in the back and held while the output is stalled.
`timescale 1ns / 1ps
`default_nettype none

module http_request_delimiter_top (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [7:0]           data_byte,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [7:0]                byte_out,
	output logic                      in_body,
	output logic                      headers_done,
	output logic                      request_end,
	output logic [hrd_pkg::BL_W-1:0]  body_length
);
	import hrd_pkg::*;

	hrd_class_t front_data;
	hrd_class_t back_data;
	logic       front_valid;
	logic       front_stall;
	logic       back_valid;
	logic       back_pop;

	hrd_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.q_valid   (front_valid),
		.q_stall   (front_stall),
		.q_data    (front_data)
	);

	hrd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_stall (front_stall),
		.push_data  (front_data),
		.pop_valid  (back_valid),
		.pop        (back_pop),
		.pop_data   (back_data)
	);

	hrd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (back_valid),
		.q_pop        (back_pop),
		.q_data       (back_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.byte_out     (byte_out),
		.in_body      (in_body),
		.headers_done (headers_done),
		.request_end  (request_end),
		.body_length  (body_length)
	);

endmodule

`default_nettype wire

FILE: tb/sv/frame_check_pkg.sv
`timescale 1ns / 1ps

package frame_check_pkg;
	import hrd_pkg::*;

	typedef enum logic [1:0] {
		STG_IDLE,
		STG_BLANKS,
		STG_DIGITS,
		STG_FINAL
	} value_stage_t;

	typedef struct packed {
		logic [7:0]      byte_val;
		logic            in_body;
		logic            hdr_done;
		logic            req_end;
		logic [BL_W-1:0] body_len;
	} frame_result_t;

	localparam logic [63:0] LEN_LIMIT = {64{1'b1}} >> (64 - LEN_BITS);

	class framing_checker;
		string         spelling [2];
		logic          body_phase;
		logic [1:0]    term_seen;
		int            name_prog [2];
		value_stage_t  stage [2];
		logic [63:0]   value [2];
		logic [63:0]   body_left;
		frame_result_t expected_frames [$];
		int            errors;

		function new();
			spelling[0] = "Content-Length:";
			spelling[1] = "content-length:";
			body_phase = 1'b0;
			body_left = '0;
			errors = 0;
			clear_header();
		endfunction

		function void clear_header();
			term_seen = '0;
			for (int k = 0; k < 2; k++) begin
				name_prog[k] = 0;
				stage[k] = STG_IDLE;
				value[k] = '0;
			end
		endfunction

		function int pending();
			return expected_frames.size();
		endfunction

		function bit body_open();
			return body_phase;
		endfunction

		function void read_digit(int k, logic [7:0] b);
			logic        is_digit;
			logic [63:0] d;
			if (stage[k] == STG_IDLE || stage[k] == STG_FINAL)
				return;
			is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
			if (stage[k] == STG_BLANKS) begin
				if (b == CH_SP || b == CH_TAB)
					return;
				if (!is_digit) begin
					value[k] = '0;
					stage[k] = STG_FINAL;
					return;
				end
				stage[k] = STG_DIGITS;
			end else if (!is_digit) begin
				stage[k] = STG_FINAL;
				return;
			end
			d = 64'(b - CH_ZERO);
			// zero the value and freeze it once it cannot fit
			if (value[k] > (LEN_LIMIT - d) / 10) begin
				value[k] = '0;
				stage[k] = STG_FINAL;
				return;
			end
			value[k] = value[k] * 10 + d;
		endfunction

		function void match_name(int k, logic [7:0] b);
			int p;
			if (stage[k] != STG_IDLE)
				return;
			p = name_prog[k];
			if (p < NAME_LEN && b == spelling[k][p])
				p = p + 1;
			else
				p = (b == spelling[k][0]) ? 1 : 0;
			if (p >= NAME_LEN) begin
				stage[k] = STG_BLANKS;
				p = 0;
			end
			name_prog[k] = p;
		endfunction

		// Predict the result of one accepted byte and queue it.
		function void take_byte(logic [7:0] b);
			frame_result_t want;
			logic [1:0]    t;
			logic [63:0]   len;
			want = '0;
			want.byte_val = b;
			if (body_phase) begin
				want.in_body = 1'b1;
				body_left = (body_left - 1) & LEN_LIMIT;
				if (body_left == 0) begin
					want.req_end = 1'b1;
					body_phase = 1'b0;
				end
			end else begin
				t = term_seen;
				// parse before matching so the byte that completes a name is not parsed
				for (int k = 0; k < 2; k++)
					read_digit(k, b);
				for (int k = 0; k < 2; k++)
					match_name(k, b);
				if (t == 2'd3 && b == CH_LF) begin
					want.hdr_done = 1'b1;
					if (stage[0] != STG_IDLE)
						len = value[0];
					else if (stage[1] != STG_IDLE)
						len = value[1];
					else
						len = '0;
					len = len & LEN_LIMIT;
					clear_header();
					if (len == 0) begin
						want.req_end = 1'b1;
					end else begin
						body_phase = 1'b1;
						body_left = len;
					end
					want.body_len = len[BL_W-1:0];
				end else if ((t == 2'd0 || t == 2'd2) && b == CH_CR) begin
					term_seen = t + 2'd1;
				end else if (t == 2'd1 && b == CH_LF) begin
					term_seen = 2'd2;
				end else begin
					term_seen = (b == CH_CR) ? 2'd1 : 2'd0;
				end
			end
			expected_frames.push_back(want);
		endfunction

		function void report_field(string field, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
			end
		endfunction

		function void check_frame(frame_result_t got);
			frame_result_t want;
			if (expected_frames.size() == 0) begin
				errors++;
				$display("%0t: result expected none, got byte %0h", $time, got.byte_val);
				return;
			end
			want = expected_frames.pop_front();
			report_field("byte_out", want.byte_val, got.byte_val);
			report_field("in_body", want.in_body, got.in_body);
			report_field("headers_done", want.hdr_done, got.hdr_done);
			report_field("request_end", want.req_end, got.req_end);
			report_field("body_length", want.body_len, got.body_len);
		endfunction
	endclass

endpackage

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import hrd_pkg::*;
	import frame_check_pkg::*;

	localparam int GAP_MAX       = 12;
	localparam int HOLD_CYCLES   = 300;
	localparam int STUCK_LIMIT   = 2000;
	localparam int RANDOM_BYTES  = 500;
	localparam int SETTLE_CYCLES = 20;

	logic            clk;
	logic            arst_n;
	logic            in_valid;
	logic            in_stall;
	logic [7:0]      data_byte;
	logic            out_valid;
	logic            out_stall;
	logic [7:0]      byte_out;
	logic            in_body;
	logic            headers_done;
	logic            request_end;
	logic [BL_W-1:0] body_length;

	framing_checker sb = new();

	bit send_calm;
	bit take_calm;
	bit long_hold;
	int sent;
	int stuck;

	http_request_delimiter_top i_dut (
		.clk,
		.arst_n,
		.in_valid,
		.in_stall,
		.data_byte,
		.out_valid,
		.out_stall,
		.byte_out,
		.in_body,
		.headers_done,
		.request_end,
		.body_length
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Offer one byte and hold it until the transfer.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = send_calm ? 0 : $urandom_range(0, GAP_MAX);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		sb.take_byte(b);
		sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_crlf();
		send_byte(CH_CR);
		send_byte(CH_LF);
	endtask

	task automatic send_line(input string s);
		send_text(s);
		send_crlf();
	endtask

	// Close the header block, then feed as many body bytes as the length asks.
	task automatic finish_request();
		send_crlf();
		while (sb.body_open())
			send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic string blanks();
		string s;
		s = "";
		repeat ($urandom_range(0, 3)) begin
			if ($urandom_range(0, 1))
				s = {s, " "};
			else
				s = {s, "\t"};
		end
		return s;
	endfunction

	// Value text; the widest legal value only where an exact-case header also wins.
	function automatic string value_text(input bit wide_ok);
		int n;
		n = $urandom_range(0, 24);
		case ($urandom_range(0, wide_ok ? 6 : 5))
			0, 1: return $sformatf("%0d", n);
			2: return $sformatf("%0d;q", n);
			3: return $sformatf("000%0d", n);
			4: return ($urandom_range(0, 1)) ? "" : "abc";
			5: return "99999999999";
			default: return "4294967295";
		endcase
	endfunction

	task automatic send_request();
		int order;
		repeat ($urandom_range(0, 2)) begin
			repeat ($urandom_range(1, 6))
				send_byte(8'($urandom_range(0, 255)));
			send_crlf();
		end
		order = $urandom_range(0, 4);
		if (order == 1 || order == 3)
			send_line({"Content-Length:", blanks(), value_text(1'b0)});
		if (order >= 2)
			send_line({"content-length:", blanks(), value_text(order != 2)});
		if (order == 4)
			send_line({"Content-Length:", blanks(), value_text(1'b0)});
		finish_request();
	endtask

	task automatic send_broken();
		string nm;
		logic [7:0] b;
		if ($urandom_range(0, 1)) begin
			// terminator cut short right before its last byte
			b = 8'($urandom_range(0, 255));
			if (b == CH_LF)
				b = 8'h00;
			send_byte(CH_CR);
			send_byte(CH_LF);
			send_byte(CH_CR);
			send_byte(b);
		end else begin
			nm = $urandom_range(0, 1) ? "content-length:" : "Content-Length:";
			send_text(nm.substr(0, $urandom_range(0, NAME_LEN - 2)));
			send_byte("X");
		end
	endtask

	task automatic run_directed();
		send_line("G");
		finish_request();
		send_line("Content-Length: 3");
		finish_request();
		send_line("content-length:\t 2");
		finish_request();
		send_line("content-length: 5");
		send_line("Content-Length: 1");
		finish_request();
		send_line("Content-Length: x");
		finish_request();
		send_line("Content-Length: \t");
		finish_request();
		send_line("Content-Length: 2ab");
		finish_request();
		send_line("Content-Length: 4294967296");
		finish_request();
		send_line("content-length: 4294967295");
		send_line("Content-Length: 0");
		finish_request();
		send_line("Content-Length: 1");
		send_line("Content-Length: 4");
		finish_request();
		send_byte(CH_CR);
		send_byte(CH_LF);
		send_byte(CH_CR);
		send_byte("X");
		send_line("Content-Lengt");
		finish_request();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_crlf();
		finish_request();
	endtask

	initial begin : stimulus
		bit mid_drained;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		send_calm = 1'b0;
		long_hold = 1'b0;
		mid_drained = 1'b0;
		sent = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		run_directed();
		drain();
		// hold the output back while bytes keep coming, to fill the block
		long_hold = 1'b1;
		while (sent < RANDOM_BYTES) begin
			send_calm = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0: repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
				1: send_broken();
				default: send_request();
			endcase
			if (!mid_drained && sent >= RANDOM_BYTES / 2) begin
				drain();
				mid_drained = 1'b1;
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin : result_taker
		int wait_n;
		frame_result_t got;
		out_stall = 1'b0;
		take_calm = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			wait_n = take_calm ? 0 : $urandom_range(0, GAP_MAX);
			if (long_hold) begin
				wait_n = HOLD_CYCLES;
				long_hold = 1'b0;
			end
			@(negedge clk);
			if (wait_n > 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			got = '{byte_out, in_body, headers_done, request_end, body_length};
			sb.check_frame(got);
			if ($urandom_range(0, 39) == 0)
				take_calm = !take_calm;
		end
	end

	initial begin : watchdog
		stuck = 0;
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stuck = 0;
			else
				stuck++;
		end
		$display("Mismatches found");
		$finish;
	end

endmodule

FILE: filelist.f
design/hrd_pkg.sv
design/hrd_front.sv
design/hrd_queue.sv
design/hrd_back.sv
design/http_request_delimiter_top.sv
tb/sv/frame_check_pkg.sv
tb/sv/tb_top.sv
